@@ rtl/core/loc_pkg.sv @@
// types and constants shared by the lock order cycle checker
package loc_pkg;

    localparam int ID_W = 6;

    typedef enum logic [1:0] {
        MODE_ALLOC = 2'd0,
        MODE_REF   = 2'd1,
        MODE_REL   = 2'd2,
        MODE_CHECK = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EDGE     = 3'd1,
        ST_CYCLE    = 3'd2,
        ST_HELD     = 3'd3,
        ST_NO_FREE  = 3'd4,
        ST_NOT_REF  = 3'd5,
        ST_SAT      = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        IDS_LOCK = 2'd0,
        IDS_GOT  = 2'd1,
        IDS_ZERO = 2'd2
    } t_idsel;

    typedef enum logic [2:0] {
        CW_NONE = 3'd0,
        CW_ZERO = 3'd1,
        CW_ONE  = 3'd2,
        CW_INC  = 3'd3,
        CW_DEC  = 3'd4
    } t_cntwr;

    typedef enum logic [1:0] {
        MR_NONE = 2'd0,
        MR_HELD = 2'd1,
        MR_NODE = 2'd2,
        MR_IDX  = 2'd3
    } t_matrd;

    typedef enum logic [1:0] {
        MW_NONE = 2'd0,
        MW_CLR  = 2'd1,
        MW_REL  = 2'd2,
        MW_ADD  = 2'd3
    } t_matwr;

    typedef struct packed {
        logic    latch;
        logic    idx_clr;
        logic    idx_inc;
        logic    cnt_rd;
        logic    cnt_rd_held;
        t_cntwr  cnt_wr;
        logic    free_clr_got;
        logic    free_set_id;
        logic    hint_clr;
        logic    hint_set;
        logic    hw_upd;
        logic    got_hint;
        logic    got_idx;
        t_matrd  mat_rd;
        t_matwr  mat_wr;
        logic    srch_init;
        logic    pop;
        logic    scan_step;
        logic    set_res;
        t_status res_status;
        t_idsel  res_id;
        logic    out_ld;
    } t_cmd;

    typedef struct packed {
        t_mode mode;
        logic  idx_last;
        logic  scan_last;
        logic  hint_ok;
        logic  free_at_idx;
        logic  id_bad;
        logic  held_bad;
        logic  cnt_max;
        logic  cnt_one;
        logic  held_eq;
        logic  bit_id;
        logic  bit_held;
        logic  sp_zero;
        logic  out_free;
    } t_sts;

endpackage

@@ rtl/core/loc_if.sv @@
// request and result channel interfaces
interface loc_in_if;
    import loc_pkg::*;
    logic            valid;
    logic            ready;
    logic [1:0]      mode;
    logic [ID_W-1:0] lock_id;
    logic [ID_W-1:0] held_id;
    modport source (output valid, output mode, output lock_id, output held_id, input ready);
    modport sink   (input valid, input mode, input lock_id, input held_id, output ready);
endinterface

interface loc_out_if;
    import loc_pkg::*;
    logic            valid;
    logic            ready;
    logic [2:0]      status;
    logic [ID_W-1:0] id_out;
    modport source (output valid, output status, output id_out, input ready);
    modport sink   (input valid, input status, input id_out, output ready);
endinterface

@@ rtl/core/lock_order_cycle_checker.sv @@
// lock order cycle checker: allocate, reference, release and order check of lock ids
// order check: one row scan per graph node, over the ids below the high-water mark
// throughput: one request at a time; the next is taken once the result sits in the output register
// reset: synchronous active low; a clearing pass over every id zeroes matrix and counts
// ready stays low during the clearing pass
module lock_order_cycle_checker #(
    parameter int MAX_IDS  = 64,
    parameter int REF_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    loc_in_if.sink   i_in,
    loc_out_if.source o_out
);
    import loc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    loc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    loc_dp #(
        .MAX_IDS  (MAX_IDS),
        .REF_BITS (REF_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_mode      (i_in.mode),
        .i_lock_id   (i_in.lock_id),
        .i_held_id   (i_in.held_id),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_status    (o_out.status),
        .o_id_out    (o_out.id_out)
    );
endmodule

@@ rtl/core/loc_dp.sv @@
// datapath: order matrix, counts, free map, search stack and result register
module loc_dp #(
    parameter int MAX_IDS  = 64,
    parameter int REF_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  loc_pkg::t_cmd             i_cmd,
    output loc_pkg::t_sts             o_sts,
    input  logic [1:0]                i_mode,
    input  logic [loc_pkg::ID_W-1:0]  i_lock_id,
    input  logic [loc_pkg::ID_W-1:0]  i_held_id,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [2:0]                o_status,
    output logic [loc_pkg::ID_W-1:0]  o_id_out
);
    import loc_pkg::*;

    localparam int IDW = $clog2(MAX_IDS);

    logic [MAX_IDS-1:0]  mat [MAX_IDS];
    logic [REF_BITS-1:0] cnt [MAX_IDS];
    logic [IDW-1:0]      stk [MAX_IDS];

    t_mode               r_mode;
    logic [ID_W-1:0]     r_id, r_held;
    logic [MAX_IDS-1:0]  r_mat_q, r_free, r_vis;
    logic [REF_BITS-1:0] r_cnt_q;
    logic [IDW-1:0]      r_stk_q, r_idx, r_got, r_hint;
    logic                r_hint_v;
    logic [IDW:0]        r_hw, r_sp;
    t_status             r_pend_st;
    logic [ID_W-1:0]     r_pend_id;
    logic                r_out_v;
    logic [2:0]          r_out_st;
    logic [ID_W-1:0]     r_out_id;

    logic [IDW+ID_W-1:0] id_ext, held_ext, got_ext;
    logic [IDW-1:0]      id_a, held_a, mat_ra, mat_wa, cnt_wa;
    logic [MAX_IDS-1:0]  mat_wd;
    logic [REF_BITS-1:0] cnt_wd;
    logic                out_free;

    assign id_ext   = {{IDW{1'b0}}, r_id};
    assign held_ext = {{IDW{1'b0}}, r_held};
    assign got_ext  = {{ID_W{1'b0}}, r_got};
    assign id_a     = id_ext[IDW-1:0];
    assign held_a   = held_ext[IDW-1:0];
    assign out_free = !r_out_v || i_out_ready;

    always_comb begin
        case (i_cmd.mat_rd)
            MR_HELD: mat_ra = held_a;
            MR_NODE: mat_ra = r_stk_q;
            default: mat_ra = r_idx;
        endcase
        mat_wa = (i_cmd.mat_wr == MW_ADD) ? held_a : r_idx;
        case (i_cmd.mat_wr)
            MW_REL:  mat_wd = (r_idx == id_a) ? '0 : (r_mat_q & ~(MAX_IDS'(1) << id_a));
            MW_ADD:  mat_wd = r_mat_q | (MAX_IDS'(1) << id_a);
            default: mat_wd = '0;
        endcase
        case (i_cmd.cnt_wr)
            CW_ONE: begin
                cnt_wa = r_got;
                cnt_wd = REF_BITS'(1);
            end
            CW_INC: begin
                cnt_wa = id_a;
                cnt_wd = r_cnt_q + REF_BITS'(1);
            end
            CW_DEC: begin
                cnt_wa = id_a;
                cnt_wd = r_cnt_q - REF_BITS'(1);
            end
            default: begin
                cnt_wa = r_idx;
                cnt_wd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mat_wr != MW_NONE) begin
            mat[mat_wa] <= mat_wd;
        end
        if (i_cmd.mat_rd != MR_NONE) begin
            r_mat_q <= mat[mat_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cnt_wr != CW_NONE) begin
            cnt[cnt_wa] <= cnt_wd;
        end
        if (i_cmd.cnt_rd) begin
            r_cnt_q <= cnt[i_cmd.cnt_rd_held ? held_a : id_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.srch_init) begin
            stk[0] <= id_a;
        end else if (i_cmd.scan_step && r_mat_q[r_idx] && !r_vis[r_idx]) begin
            stk[r_sp[IDW-1:0]] <= r_idx;
        end
        if (i_cmd.pop) begin
            r_stk_q <= stk[r_sp[IDW-1:0] - IDW'(1)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode <= t_mode'(i_mode);
            r_id   <= i_lock_id;
            r_held <= i_held_id;
        end
        if (i_cmd.got_hint) begin
            r_got <= r_hint;
        end else if (i_cmd.got_idx) begin
            r_got <= r_idx;
        end
        if (i_cmd.srch_init) begin
            r_vis <= MAX_IDS'(1) << id_a;
        end else if (i_cmd.scan_step && r_mat_q[r_idx]) begin
            r_vis[r_idx] <= 1'b1;
        end
        if (i_cmd.set_res) begin
            r_pend_st <= i_cmd.res_status;
            case (i_cmd.res_id)
                IDS_GOT:  r_pend_id <= got_ext[ID_W-1:0];
                IDS_ZERO: r_pend_id <= '0;
                default:  r_pend_id <= r_id;
            endcase
        end
        if (i_cmd.out_ld) begin
            r_out_st <= r_pend_st;
            r_out_id <= r_pend_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free   <= '1;
            r_hint_v <= 1'b0;
            r_hint   <= '0;
            r_hw     <= '0;
            r_idx    <= '0;
            r_sp     <= '0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + IDW'(1);
            end
            if (i_cmd.free_clr_got) begin
                r_free[r_got] <= 1'b0;
            end else if (i_cmd.free_set_id) begin
                r_free[id_a] <= 1'b1;
            end
            if (i_cmd.hint_set) begin
                r_hint_v <= 1'b1;
                r_hint   <= id_a;
            end else if (i_cmd.hint_clr) begin
                r_hint_v <= 1'b0;
            end
            if (i_cmd.hw_upd && (r_hw <= {1'b0, r_got})) begin
                r_hw <= {1'b0, r_got} + (IDW+1)'(1);
            end
            if (i_cmd.srch_init) begin
                r_sp <= (IDW+1)'(1);
            end else if (i_cmd.pop) begin
                r_sp <= r_sp - (IDW+1)'(1);
            end else if (i_cmd.scan_step && r_mat_q[r_idx] && !r_vis[r_idx]) begin
                r_sp <= r_sp + (IDW+1)'(1);
            end
            if (i_cmd.out_ld) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.mode        = r_mode;
        o_sts.idx_last    = (r_idx == IDW'(MAX_IDS - 1));
        o_sts.scan_last   = (({1'b0, r_idx} + (IDW+1)'(1)) >= r_hw);
        o_sts.hint_ok     = r_hint_v && r_free[r_hint];
        o_sts.free_at_idx = r_free[r_idx];
        o_sts.id_bad      = (int'(r_id) >= MAX_IDS) || (r_cnt_q == '0);
        o_sts.held_bad    = (int'(r_held) >= MAX_IDS) || (r_cnt_q == '0);
        o_sts.cnt_max     = (r_cnt_q == '1);
        o_sts.cnt_one     = (r_cnt_q == REF_BITS'(1));
        o_sts.held_eq     = (r_held == r_id);
        o_sts.bit_id      = r_mat_q[id_a];
        o_sts.bit_held    = r_mat_q[held_a];
        o_sts.sp_zero     = (r_sp == '0);
        o_sts.out_free    = out_free;
    end

    assign o_out_valid = r_out_v;
    assign o_status    = r_out_st;
    assign o_id_out    = r_out_id;

    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= (IDW+1)'(MAX_IDS)) else $error("search stack overflow");
    a_hw_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hw <= (IDW+1)'(MAX_IDS)) else $error("high water beyond id range");
    a_alloc_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.free_clr_got |=> !r_free[$past(r_got)]) else $error("allocated id still free");
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_ld |-> out_free) else $error("result overwritten before transfer");
endmodule

@@ rtl/core/loc_ctrl.sv @@
// controller state machine sequencing each operation
module loc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  loc_pkg::t_sts i_sts,
    output loc_pkg::t_cmd o_cmd
);
    import loc_pkg::*;

    typedef enum logic [15:0] {
        S_CLR   = 16'h0001,
        S_IDLE  = 16'h0002,
        S_DEC   = 16'h0004,
        S_FSCAN = 16'h0008,
        S_ALW   = 16'h0010,
        S_CHK   = 16'h0020,
        S_CHKH  = 16'h0040,
        S_CHKM  = 16'h0080,
        S_POP   = 16'h0100,
        S_NODE  = 16'h0200,
        S_ROW   = 16'h0400,
        S_SCAN  = 16'h0800,
        S_ADD   = 16'h1000,
        S_RELRD = 16'h2000,
        S_RELWR = 16'h4000,
        S_DONE  = 16'h8000
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd = '0;
        n_state = r_state;
        case (r_state)
            S_CLR: begin
                o_cmd.mat_wr = MW_CLR;
                o_cmd.cnt_wr = CW_ZERO;
                if (i_sts.idx_last) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (i_sts.mode == MODE_ALLOC) begin
                    o_cmd.hint_clr = 1'b1;
                    if (i_sts.hint_ok) begin
                        o_cmd.got_hint = 1'b1;
                        n_state = S_ALW;
                    end else begin
                        o_cmd.idx_clr = 1'b1;
                        n_state = S_FSCAN;
                    end
                end else begin
                    o_cmd.cnt_rd = 1'b1;
                    n_state = S_CHK;
                end
            end
            S_FSCAN: begin
                if (i_sts.free_at_idx) begin
                    o_cmd.got_idx = 1'b1;
                    n_state = S_ALW;
                end else if (i_sts.idx_last) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res_status = ST_NO_FREE;
                    o_cmd.res_id = IDS_ZERO;
                    n_state = S_DONE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_ALW: begin
                o_cmd.free_clr_got = 1'b1;
                o_cmd.cnt_wr = CW_ONE;
                o_cmd.hw_upd = 1'b1;
                o_cmd.set_res = 1'b1;
                o_cmd.res_status = ST_OK;
                o_cmd.res_id = IDS_GOT;
                n_state = S_DONE;
            end
            S_CHK: begin
                o_cmd.set_res = 1'b1;
                o_cmd.res_id = IDS_LOCK;
                o_cmd.res_status = ST_OK;
                n_state = S_DONE;
                if (i_sts.id_bad) begin
                    o_cmd.res_status = ST_NOT_REF;
                end else if (i_sts.mode == MODE_REF) begin
                    if (i_sts.cnt_max) begin
                        o_cmd.res_status = ST_SAT;
                    end else begin
                        o_cmd.cnt_wr = CW_INC;
                    end
                end else if (i_sts.mode == MODE_REL) begin
                    o_cmd.cnt_wr = CW_DEC;
                    if (i_sts.cnt_one) begin
                        o_cmd.free_set_id = 1'b1;
                        o_cmd.hint_set = 1'b1;
                        o_cmd.idx_clr = 1'b1;
                        n_state = S_RELRD;
                    end
                end else if (i_sts.held_eq) begin
                    o_cmd.res_status = ST_HELD;
                end else begin
                    o_cmd.set_res = 1'b0;
                    o_cmd.cnt_rd = 1'b1;
                    o_cmd.cnt_rd_held = 1'b1;
                    n_state = S_CHKH;
                end
            end
            S_CHKH: begin
                if (i_sts.held_bad) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res_status = ST_NOT_REF;
                    o_cmd.res_id = IDS_LOCK;
                    n_state = S_DONE;
                end else begin
                    o_cmd.mat_rd = MR_HELD;
                    n_state = S_CHKM;
                end
            end
            S_CHKM: begin
                if (i_sts.bit_id) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res_status = ST_OK;
                    o_cmd.res_id = IDS_LOCK;
                    n_state = S_DONE;
                end else begin
                    o_cmd.srch_init = 1'b1;
                    n_state = S_POP;
                end
            end
            S_POP: begin
                if (i_sts.sp_zero) begin
                    o_cmd.mat_rd = MR_HELD;
                    n_state = S_ADD;
                end else begin
                    o_cmd.pop = 1'b1;
                    n_state = S_NODE;
                end
            end
            S_NODE: begin
                o_cmd.mat_rd = MR_NODE;
                n_state = S_ROW;
            end
            S_ROW: begin
                if (i_sts.bit_held) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res_status = ST_CYCLE;
                    o_cmd.res_id = IDS_LOCK;
                    n_state = S_DONE;
                end else begin
                    o_cmd.idx_clr = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_POP;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_ADD: begin
                o_cmd.mat_wr = MW_ADD;
                o_cmd.set_res = 1'b1;
                o_cmd.res_status = ST_EDGE;
                o_cmd.res_id = IDS_LOCK;
                n_state = S_DONE;
            end
            S_RELRD: begin
                o_cmd.mat_rd = MR_IDX;
                n_state = S_RELWR;
            end
            S_RELWR: begin
                o_cmd.mat_wr = MW_REL;
                if (i_sts.idx_last) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state = S_RELRD;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    a_clr_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> !o_cmd.latch) else $error("transfer during clearing pass");
    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && i_sts.out_free |=> (r_state == S_IDLE))
        else $error("finished result not loaded");
    a_one_mat_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.mat_wr != MW_NONE) |-> (o_cmd.mat_rd == MR_NONE))
        else $error("matrix read and write in one cycle");
endmodule

@@ test/tb_top.sv @@
// testbench for the lock order cycle checker: scoreboard predicts each result from accepted requests
`timescale 1ns / 100ps

class lock_order_scoreboard;
    bit [63:0] free_ids;
    bit [63:0] order_rows [64];
    int unsigned use_count [64];
    bit hint_ok;
    int unsigned hint_id;
    int unsigned top_id;
    bit [2:0] exp_status [$];
    bit [5:0] exp_id [$];
    int fails;

    function new();
        free_ids = '1;
        foreach (order_rows[k]) order_rows[k] = '0;
        foreach (use_count[k]) use_count[k] = 0;
        hint_ok = 0;
        hint_id = 0;
        top_id = 0;
        fails = 0;
    endfunction

    function bit path_exists(int unsigned src, int unsigned dst);
        bit [63:0] seen;
        int unsigned pend [$];
        int unsigned node;
        seen = '0;
        seen[src] = 1;
        pend.push_back(src);
        while (pend.size() > 0) begin
            node = pend.pop_back();
            if (order_rows[node][dst]) return 1;
            for (int k = 0; k < top_id && k < 64; k++) begin
                if (order_rows[node][k] && !seen[k]) begin
                    seen[k] = 1;
                    pend.push_back(k);
                end
            end
        end
        return 0;
    endfunction

    function void note_request(loc_pkg::t_mode mode, bit [5:0] lid, bit [5:0] hid);
        loc_pkg::t_status st;
        bit [5:0] rid;
        bit found;
        int unsigned got;
        st = loc_pkg::ST_OK;
        rid = lid;
        if (mode == loc_pkg::MODE_ALLOC) begin
            found = 0;
            got = 0;
            if (hint_ok && free_ids[hint_id]) begin
                got = hint_id;
                found = 1;
            end
            hint_ok = 0;
            for (int k = 0; k < 64 && !found; k++) begin
                if (free_ids[k]) begin
                    got = k;
                    found = 1;
                end
            end
            if (found) begin
                free_ids[got] = 0;
                use_count[got] = 1;
                if (top_id <= got) top_id = got + 1;
                rid = got;
            end else begin
                st = loc_pkg::ST_NO_FREE;
                rid = 0;
            end
        end else if (use_count[lid] == 0) begin
            st = loc_pkg::ST_NOT_REF;
        end else if (mode == loc_pkg::MODE_REF) begin
            if (use_count[lid] >= 16'hFFFF) st = loc_pkg::ST_SAT;
            else use_count[lid]++;
        end else if (mode == loc_pkg::MODE_REL) begin
            use_count[lid]--;
            if (use_count[lid] == 0) begin
                order_rows[lid] = '0;
                foreach (order_rows[k]) order_rows[k][lid] = 0;
                free_ids[lid] = 1;
                hint_id = lid;
                hint_ok = 1;
            end
        end else begin
            if (hid == lid) st = loc_pkg::ST_HELD;
            else if (use_count[hid] == 0) st = loc_pkg::ST_NOT_REF;
            else if (!order_rows[hid][lid]) begin
                if (path_exists(lid, hid)) st = loc_pkg::ST_CYCLE;
                else begin
                    order_rows[hid][lid] = 1;
                    st = loc_pkg::ST_EDGE;
                end
            end
        end
        exp_status.push_back(st);
        exp_id.push_back(rid);
    endfunction

    function void check_result(bit [2:0] status, bit [5:0] id_out);
        bit [2:0] es;
        bit [5:0] ei;
        if (exp_status.size() == 0) begin
            $error("result with nothing pending: status %0d id_out %0d", status, id_out);
            fails++;
            return;
        end
        es = exp_status.pop_front();
        ei = exp_id.pop_front();
        if (status !== es) begin
            $error("status: expected %0d actual %0d", es, status);
            fails++;
        end
        if (id_out !== ei) begin
            $error("id_out: expected %0d actual %0d", ei, id_out);
            fails++;
        end
    endfunction
endclass

module tb_top;
    import loc_pkg::*;

    logic i_clk = 0;
    logic i_rst_n = 0;
    loc_in_if  req_ch ();
    loc_out_if res_ch ();

    lock_order_cycle_checker u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch.sink),
        .o_out   (res_ch.source)
    );

    always #5 i_clk = ~i_clk;

    lock_order_scoreboard lock_sb = new();
    bit quiet_phase = 0;
    bit hold_results = 0;
    bit stim_done = 0;
    int idle_cycles = 0;
    bit [5:0] live_ids [$];

    initial begin
        req_ch.valid = 0;
        req_ch.mode = MODE_ALLOC;
        req_ch.lock_id = 0;
        req_ch.held_id = 0;
        res_ch.ready = 0;
    end

    // result side: random stalls, one long hold-off
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready)
            lock_sb.check_result(res_ch.status, res_ch.id_out);
    end

    initial begin
        @(posedge i_clk iff i_rst_n);
        while (1) begin
            if (hold_results) begin
                res_ch.ready <= 0;
                repeat (2000) @(posedge i_clk);
                hold_results = 0;
            end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
                res_ch.ready <= 0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end else begin
                res_ch.ready <= 1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_request(t_mode mode, bit [5:0] lid, bit [5:0] hid);
        if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        req_ch.valid <= 1;
        req_ch.mode <= mode;
        req_ch.lock_id <= lid;
        req_ch.held_id <= hid;
        @(posedge i_clk iff req_ch.ready);
        lock_sb.note_request(mode, lid, hid);
        if (mode == MODE_ALLOC && lock_sb.exp_status[$] != ST_NO_FREE)
            live_ids.push_back(lock_sb.exp_id[$]);
    endtask

    function automatic bit [5:0] pick_id();
        if (live_ids.size() > 0 && $urandom_range(0, 7) != 0)
            return live_ids[$urandom_range(0, live_ids.size() - 1)];
        return 6'($urandom_range(0, 63));
    endfunction

    initial begin
        int pick;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        // directed: error cases, allocation, chain and cycle
        send_request(MODE_REF, 6'd63, 6'd0);
        send_request(MODE_REL, 6'd0, 6'd0);
        send_request(MODE_CHECK, 6'd5, 6'd5);
        send_request(MODE_CHECK, 6'd1, 6'd2);
        repeat (4) send_request(MODE_ALLOC, 6'd0, 6'd0);
        send_request(MODE_CHECK, 6'd1, 6'd0);
        send_request(MODE_CHECK, 6'd1, 6'd0);
        send_request(MODE_CHECK, 6'd2, 6'd1);
        send_request(MODE_CHECK, 6'd0, 6'd2);
        send_request(MODE_CHECK, 6'd3, 6'd63);
        send_request(MODE_REF, 6'd1, 6'd0);
        send_request(MODE_REL, 6'd1, 6'd0);
        send_request(MODE_REL, 6'd1, 6'd0);
        send_request(MODE_CHECK, 6'd0, 6'd2);
        send_request(MODE_ALLOC, 6'd0, 6'd0);
        // fill every id, then overflow
        repeat (61) send_request(MODE_ALLOC, 6'($urandom), 6'($urandom));
        send_request(MODE_ALLOC, 6'd0, 6'd0);
        send_request(MODE_CHECK, 6'd63, 6'd62);
        send_request(MODE_CHECK, 6'd0, 6'd63);
        send_request(MODE_REF, 6'd10, 6'd0);
        hold_results = 1;
        for (int n = 0; n < 320; n++) begin
            if (n == 240) quiet_phase = 1;
            pick = $urandom_range(0, 9);
            if (pick < 1)
                send_request(MODE_ALLOC, 6'($urandom), 6'($urandom));
            else if (pick < 3)
                send_request(MODE_REF, pick_id(), 6'($urandom));
            else if (pick < 5)
                send_request(MODE_REL, pick_id(), 6'($urandom));
            else
                send_request(MODE_CHECK, pick_id(), pick_id());
        end
        req_ch.valid <= 0;
        stim_done = 1;
        wait (lock_sb.exp_status.size() == 0);
        repeat (300) @(posedge i_clk);
        if (lock_sb.fails == 0 && lock_sb.exp_status.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
